### hdl/reno_cw_pkg.sv
// Package for the Reno congestion window sender: payload structs, request,
// phase and timer codes, window constants and the saturating window add.
// No dependencies.
`timescale 1ns / 1ps

package reno_cw_pkg;

	localparam int MAX_WINDOW = 1024;
	localparam int SEQ_WIDTH  = 16;
	localparam int WIDE_WIDTH = SEQ_WIDTH + 1;
	localparam int WIN_WIDTH  = 11;

	localparam logic [WIN_WIDTH-1:0] WIN_MAX   = WIN_WIDTH'(MAX_WINDOW);
	localparam logic [WIN_WIDTH-1:0] AVOID_MAX = '1;
	localparam logic [WIN_WIDTH-1:0] THRESH_RESET = WIN_WIDTH'(64);
	localparam logic [1:0] DUP_LIMIT = 2'd3;

	// request codes
	localparam logic [1:0] REQ_SEND    = 2'd0;
	localparam logic [1:0] REQ_ACK     = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	// timer commands
	localparam logic [1:0] TMR_LEAVE   = 2'd0;
	localparam logic [1:0] TMR_RESTART = 2'd1;
	localparam logic [1:0] TMR_STOP    = 2'd2;

	typedef enum logic [1:0] {
		PH_SLOW  = 2'd0,
		PH_AVOID = 2'd1,
		PH_RECOV = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [SEQ_WIDTH-1:0] ack_number;
		logic                 ack_flag;
		logic [SEQ_WIDTH-1:0] peer_sequence;
		logic                 chunk_available;
		logic                 chunk_is_final;
	} evt_t;

	typedef struct packed {
		logic                 send_valid;
		logic [SEQ_WIDTH-1:0] send_number;
		logic                 send_is_new;
		logic                 send_fin;
		logic [SEQ_WIDTH-1:0] piggyback_ack;
		logic [1:0]           timer_cmd;
		logic [WIN_WIDTH-1:0] window_now;
		logic [WIN_WIDTH-1:0] threshold_now;
		logic [1:0]           phase_now;
		logic                 transfer_done;
	} res_t;

	// window add that stops at the maximum window
	function automatic logic [WIN_WIDTH-1:0] win_grow(input logic [WIN_WIDTH-1:0] w,
		input logic [1:0] by);
		logic [WIN_WIDTH:0] sum;
		sum = {1'b0, w} + {{(WIN_WIDTH-1){1'b0}}, by};
		return (sum > {1'b0, WIN_MAX}) ? WIN_MAX : sum[WIN_WIDTH-1:0];
	endfunction

endpackage

### hdl/reno_congestion_window_sender.sv
// Go-back-N sender window with Reno congestion control, one event per item.
// Depends on reno_cw_pkg.
`timescale 1ns / 1ps

// Channel   Signals                         Width          Direction
// evt       evt_valid / evt_ready / evt     evt_t          in
// res       res_valid / res_ready / res     res_t          out
// cfg       cfg_we / cfg_wdata              11             in
//
// Each item passes from acceptance through the input register, then through
// the update logic into the result register.
// One item per cycle is sustained while results are taken; state updates as an item leaves stage 1, unless cfg_we wins.
// A stalled result holds stage 2; stage 1 still takes one more item if it is empty.
// Reset (arst_n low) returns all window state to its initial values; window resets to 1, threshold to 64.
module reno_congestion_window_sender (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_ready,
	input  reno_cw_pkg::evt_t evt,
	output logic              res_valid,
	input  logic              res_ready,
	output reno_cw_pkg::res_t res,
	input  logic              cfg_we,
	input  logic [reno_cw_pkg::WIN_WIDTH-1:0] cfg_wdata
);
	import reno_cw_pkg::*;

	// pipeline registers
	logic valid_s1, valid_s2;
	evt_t evt_s1;
	res_t res_s2;
	logic adv;

	// window state
	phase_t                phase_q, phase_nxt;
	logic [WIN_WIDTH-1:0]  cwnd_q, cwnd_nxt;
	logic [WIN_WIDTH-1:0]  ssthresh_q, ssthresh_nxt;
	logic [1:0]            dup_q, dup_nxt;
	logic [WIN_WIDTH-1:0]  avoid_q, avoid_nxt;
	logic [WIDE_WIDTH-1:0] last_acked_q, last_acked_nxt;
	logic [SEQ_WIDTH-1:0]  next_num_q, next_num_nxt;
	logic [WIDE_WIDTH-1:0] base_q, base_nxt;
	logic [WIDE_WIDTH-1:0] taken_q, taken_nxt;
	logic                  ended_q, ended_nxt;
	logic [SEQ_WIDTH-1:0]  peer_q, peer_nxt;

	// step logic
	logic [WIDE_WIDTH:0]   win_end;
	logic [WIDE_WIDTH-1:0] next_wide;
	logic [WIDE_WIDTH-1:0] last_taken;
	logic [WIDE_WIDTH-1:0] ack_wide;
	logic                  in_window, have_old, can_new;
	logic [WIN_WIDTH-1:0]  half_cwnd;
	res_t                  res_nxt;

	assign adv       = valid_s1 && (!valid_s2 || res_ready);
	assign evt_ready = !valid_s1 || adv;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	// shared terms on current state
	assign next_wide  = {1'b0, next_num_q};
	assign win_end    = {1'b0, base_q} + {{(WIDE_WIDTH+1-WIN_WIDTH){1'b0}}, cwnd_q};
	assign last_taken = taken_q - 1'b1;
	assign ack_wide   = {1'b0, evt_s1.ack_number};
	assign in_window  = {1'b0, next_wide} < win_end;
	assign have_old   = next_wide < taken_q;
	assign can_new    = !have_old && !ended_q && evt_s1.chunk_available;
	assign half_cwnd  = cwnd_q >> 1;

	// state update and result for the item in stage 1
	always_comb begin
		phase_nxt      = phase_q;
		cwnd_nxt       = cwnd_q;
		ssthresh_nxt   = ssthresh_q;
		dup_nxt        = dup_q;
		avoid_nxt      = avoid_q;
		last_acked_nxt = last_acked_q;
		next_num_nxt   = next_num_q;
		base_nxt       = base_q;
		taken_nxt      = taken_q;
		ended_nxt      = ended_q;
		peer_nxt       = peer_q;
		res_nxt        = '0;

		case (evt_s1.req_type)
			REQ_SEND: begin
				if (in_window && (have_old || can_new)) begin
					res_nxt.send_valid  = 1'b1;
					res_nxt.send_number = next_num_q;
					if (can_new) begin
						res_nxt.send_is_new   = 1'b1;
						res_nxt.piggyback_ack = peer_q;
						res_nxt.send_fin      = evt_s1.chunk_is_final;
						ended_nxt             = ended_q | evt_s1.chunk_is_final;
						taken_nxt             = taken_q + 1'b1;
					end else begin
						res_nxt.send_fin = ended_q && (next_wide == last_taken);
					end
					if (next_wide == base_q) begin
						res_nxt.timer_cmd = TMR_RESTART;
					end
					next_num_nxt = next_num_q + 1'b1;
				end
			end
			REQ_ACK: begin
				if (evt_s1.ack_flag) begin
					base_nxt = ack_wide + 1'b1;
					peer_nxt = evt_s1.peer_sequence;
					res_nxt.timer_cmd = (next_wide == base_nxt) ? TMR_STOP : TMR_RESTART;
					if (last_acked_q == ack_wide) begin
						// duplicate ack
						if (phase_q == PH_RECOV) begin
							cwnd_nxt = win_grow(cwnd_q, 2'd1);
						end else begin
							if (dup_q < DUP_LIMIT) begin
								dup_nxt = dup_q + 1'b1;
							end
							if (dup_nxt >= DUP_LIMIT) begin
								ssthresh_nxt = half_cwnd;
								cwnd_nxt     = win_grow(half_cwnd, 2'd3);
								next_num_nxt = base_nxt[SEQ_WIDTH-1:0];
								phase_nxt    = PH_RECOV;
							end
						end
					end else begin
						// new ack
						last_acked_nxt = ack_wide;
						dup_nxt        = '0;
						if (phase_q == PH_SLOW) begin
							cwnd_nxt = win_grow(cwnd_q, 2'd1);
						end else if (phase_q == PH_AVOID) begin
							if (avoid_q < AVOID_MAX) begin
								avoid_nxt = avoid_q + 1'b1;
							end
							if (avoid_nxt >= cwnd_q) begin
								cwnd_nxt  = win_grow(cwnd_q, 2'd1);
								avoid_nxt = '0;
							end
						end else begin
							cwnd_nxt  = ssthresh_q;
							phase_nxt = PH_AVOID;
						end
					end
					if (phase_nxt == PH_SLOW && cwnd_nxt >= ssthresh_nxt) begin
						phase_nxt = PH_AVOID;
					end
				end
			end
			REQ_TIMEOUT: begin
				ssthresh_nxt = half_cwnd;
				cwnd_nxt     = WIN_WIDTH'(1);
				dup_nxt      = '0;
				next_num_nxt = base_q[SEQ_WIDTH-1:0];
				phase_nxt    = PH_SLOW;
			end
			default: begin
			end
		endcase

		res_nxt.window_now    = cwnd_nxt;
		res_nxt.threshold_now = ssthresh_nxt;
		res_nxt.phase_now     = phase_nxt;
		res_nxt.transfer_done = ended_nxt && (last_acked_nxt == (taken_nxt - 1'b1));
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (evt_ready) begin
				valid_s1 <= evt_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			evt_s1 <= evt;
		end
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	// window state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SLOW;
			cwnd_q       <= WIN_WIDTH'(1);
			ssthresh_q   <= THRESH_RESET;
			dup_q        <= '0;
			avoid_q      <= '0;
			last_acked_q <= '1;
			next_num_q   <= '0;
			base_q       <= '0;
			taken_q      <= '0;
			ended_q      <= 1'b0;
			peer_q       <= '0;
		end else if (cfg_we) begin
			ssthresh_q <= cfg_wdata;
		end else if (adv) begin
			phase_q      <= phase_nxt;
			cwnd_q       <= cwnd_nxt;
			ssthresh_q   <= ssthresh_nxt;
			dup_q        <= dup_nxt;
			avoid_q      <= avoid_nxt;
			last_acked_q <= last_acked_nxt;
			next_num_q   <= next_num_nxt;
			base_q       <= base_nxt;
			taken_q      <= taken_nxt;
			ended_q      <= ended_nxt;
			peer_q       <= peer_nxt;
		end
	end

endmodule

### tb/sv/reno_congestion_window_sender_test.sv
// Self-checking bench for the Reno congestion window sender: directed events, random
// traffic at several thresholds, window saturation and end of transfer, all checked
// against an in-bench model of the window. Depends on reno_cw_pkg and the sender RTL.
`timescale 1ns / 1ps

module reno_congestion_window_sender_test;
	import reno_cw_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_ready;
	evt_t evt_item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res_item;
	logic cfg_we = 1'b0;
	logic [WIN_WIDTH-1:0] cfg_wdata = '0;

	// window model state
	logic [WIN_WIDTH-1:0]  m_cwnd, m_thresh, m_avoid;
	phase_t                m_phase;
	logic [1:0]            m_dups;
	logic [WIDE_WIDTH-1:0] m_last_ack, m_base, m_taken;
	logic [SEQ_WIDTH-1:0]  m_next, m_peer;
	logic                  m_ended;

	res_t window_results[$];
	res_t want;
	int   mismatches = 0;
	int   cycles = 0;
	bit   calm = 1'b0;
	bit   fin_allowed = 1'b0;

	reno_congestion_window_sender u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("reno_congestion_window_sender_test: FAIL");
			$finish;
		end
	end

	// mostly short gaps, a few long ones; none while calm
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic logic [WIN_WIDTH-1:0] window_add(input logic [WIN_WIDTH-1:0] w,
		input int unsigned by);
		int unsigned sum;
		sum = w + by;
		return (sum > MAX_WINDOW) ? WIN_MAX : sum[WIN_WIDTH-1:0];
	endfunction

	// apply one event to the model and return the result it should produce
	function automatic res_t advance_window(input evt_t e);
		res_t r;
		bit in_win, have_old, take_new;
		r = '0;
		case (e.req_type)
			REQ_SEND: begin
				in_win = 32'(m_next) < 32'(m_base) + 32'(m_cwnd);
				have_old = {1'b0, m_next} < m_taken;
				take_new = !have_old && !m_ended && e.chunk_available;
				if (in_win && (have_old || take_new)) begin
					r.send_valid = 1'b1;
					r.send_number = m_next;
					if (take_new) begin
						r.send_is_new = 1'b1;
						r.piggyback_ack = m_peer;
						r.send_fin = e.chunk_is_final;
						if (e.chunk_is_final)
							m_ended = 1'b1;
						m_taken = m_taken + 1'b1;
					end else begin
						r.send_fin = m_ended && ({1'b0, m_next} == m_taken - 1'b1);
					end
					if ({1'b0, m_next} == m_base)
						r.timer_cmd = TMR_RESTART;
					m_next = m_next + 1'b1;
				end
			end
			REQ_ACK: begin
				if (e.ack_flag) begin
					m_base = {1'b0, e.ack_number} + 1'b1;
					m_peer = e.peer_sequence;
					r.timer_cmd = ({1'b0, m_next} == m_base) ? TMR_STOP : TMR_RESTART;
					if (m_last_ack == {1'b0, e.ack_number}) begin
						// duplicate: grow in recovery, else count toward fast retransmit
						if (m_phase == PH_RECOV) begin
							m_cwnd = window_add(m_cwnd, 1);
						end else begin
							if (m_dups < DUP_LIMIT)
								m_dups++;
							if (m_dups >= DUP_LIMIT) begin
								m_thresh = m_cwnd >> 1;
								m_cwnd = window_add(m_thresh, 3);
								m_next = m_base[SEQ_WIDTH-1:0];
								m_phase = PH_RECOV;
							end
						end
					end else begin
						m_last_ack = {1'b0, e.ack_number};
						m_dups = '0;
						case (m_phase)
							PH_SLOW: m_cwnd = window_add(m_cwnd, 1);
							PH_AVOID: begin
								if (m_avoid != AVOID_MAX)
									m_avoid++;
								if (m_avoid >= m_cwnd) begin
									m_cwnd = window_add(m_cwnd, 1);
									m_avoid = '0;
								end
							end
							default: begin
								m_cwnd = m_thresh;
								m_phase = PH_AVOID;
							end
						endcase
					end
					if (m_phase == PH_SLOW && m_cwnd >= m_thresh)
						m_phase = PH_AVOID;
				end
			end
			REQ_TIMEOUT: begin
				m_thresh = m_cwnd >> 1;
				m_cwnd = WIN_WIDTH'(1);
				m_dups = '0;
				m_next = m_base[SEQ_WIDTH-1:0];
				m_phase = PH_SLOW;
			end
			default: ;
		endcase
		r.window_now = m_cwnd;
		r.threshold_now = m_thresh;
		r.phase_now = m_phase;
		r.transfer_done = m_ended && (m_last_ack == m_taken - 1'b1);
		return r;
	endfunction

	function automatic evt_t ev(input logic [1:0] kind, input logic [SEQ_WIDTH-1:0] ackno,
		input logic flag, input logic [SEQ_WIDTH-1:0] peer, input logic avail,
		input logic fin);
		evt_t e;
		e.req_type = kind;
		e.ack_number = ackno;
		e.ack_flag = flag;
		e.peer_sequence = peer;
		e.chunk_available = avail;
		e.chunk_is_final = fin;
		return e;
	endfunction

	// well-formed traffic: sends, acks of packets in flight, duplicates, timeouts, some noise
	function automatic evt_t traffic_item();
		evt_t e;
		int unsigned r;
		int lo, hi;
		e = ev(REQ_SEND, 16'($urandom), $urandom_range(0, 19) != 0, 16'($urandom),
			$urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
		r = $urandom_range(0, 99);
		if (r < 45) begin
			e.req_type = REQ_SEND;
		end else if (r < 85) begin
			e.req_type = REQ_ACK;
			if (r < 57 && m_last_ack != '1) begin
				e.ack_number = m_last_ack[SEQ_WIDTH-1:0];
			end else begin
				lo = int'(m_base) - 1;
				if (lo < 0)
					lo = 0;
				hi = int'(m_next) - 1;
				if (hi < lo)
					hi = lo;
				e.ack_number = 16'(lo + int'($urandom_range(hi - lo, 0)));
			end
		end else if (r < 91) begin
			e.req_type = REQ_TIMEOUT;
		end else begin
			e.req_type = 2'($urandom);
		end
		return e;
	endfunction

	// offer one item, wait for acceptance, record what it should produce
	task automatic send_evt(input evt_t item);
		evt_t e;
		res_t predicted;
		int unsigned gap;
		e = item;
		// keep the source open unless this test ends the transfer
		if (!fin_allowed && e.req_type == REQ_SEND && e.chunk_available && !m_ended &&
			!({1'b0, m_next} < m_taken) && (32'(m_next) < 32'(m_base) + 32'(m_cwnd)))
			e.chunk_is_final = 1'b0;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_item <= e;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (!evt_ready)
			@(posedge clk);
		predicted = advance_window(e);
		window_results = {window_results, predicted};
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		evt_valid <= 1'b0;
		while (window_results.size() != 0)
			@(negedge clk);
	endtask

	// drain, then load a new threshold while the block is idle
	task automatic prepare_phase(input logic [WIN_WIDTH-1:0] thresh, input bit no_idle);
		wait_results_done();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= thresh;
		@(negedge clk);
		cfg_we <= 1'b0;
		m_thresh = thresh;
		calm = no_idle;
	endtask

	task automatic test_directed();
		prepare_phase(11'd4, 1'b0);
		// unknown request and an ack without the ACK bit change nothing
		send_evt(ev(REQ_UNKNOWN, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1));
		send_evt(ev(REQ_ACK, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 1'b1));
		// no chunk available: refused
		send_evt(ev(REQ_SEND, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1));
		send_evt(ev(REQ_SEND, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0));
		send_evt(ev(REQ_ACK, 16'h0000, 1'b1, 16'hFFFF, 1'b0, 1'b0));
		send_evt(ev(REQ_SEND, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0));
		send_evt(ev(REQ_SEND, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0));
		// window full
		send_evt(ev(REQ_SEND, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0));
		// three duplicates enter fast recovery, then retransmit and grow
		repeat (3) send_evt(ev(REQ_ACK, 16'h0000, 1'b1, 16'h1234, 1'b0, 1'b0));
		send_evt(ev(REQ_SEND, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0));
		send_evt(ev(REQ_ACK, 16'h0000, 1'b1, 16'h4321, 1'b0, 1'b0));
		send_evt(ev(REQ_ACK, 16'h0001, 1'b1, 16'h4321, 1'b0, 1'b0));
		// timeout to a zero threshold, then the top ack number
		send_evt(ev(REQ_TIMEOUT, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0));
		send_evt(ev(REQ_ACK, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0));
		// timeout wraps next number to zero
		send_evt(ev(REQ_TIMEOUT, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1));
		send_evt(ev(REQ_SEND, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0));
		// recovery from a window of one leaves a zero window on exit
		repeat (3) send_evt(ev(REQ_ACK, 16'hFFFF, 1'b1, 16'h00FF, 1'b0, 1'b0));
		send_evt(ev(REQ_ACK, 16'h0000, 1'b1, 16'hFF00, 1'b0, 1'b0));
		send_evt(ev(REQ_SEND, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0));
		send_evt(ev(REQ_SEND, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0));
		send_evt(ev(REQ_ACK, 16'h0001, 1'b1, 16'h0000, 1'b0, 1'b0));
	endtask

	task automatic test_random_traffic(input logic [WIN_WIDTH-1:0] thresh, input bit no_idle);
		prepare_phase(thresh, no_idle);
		repeat (70)
			send_evt(traffic_item());
	endtask

	// long run of duplicates in recovery drives the window into its ceiling
	task automatic test_window_saturation();
		evt_t e;
		int unsigned r, pinned, count;
		prepare_phase(11'd1023, 1'b1);
		pinned = 0;
		count = 0;
		send_evt(ev(REQ_ACK, m_last_ack[SEQ_WIDTH-1:0] + 1'b1, 1'b1, 16'($urandom),
			1'b1, 1'b0));
		while (pinned < 8 && count < 1600) begin
			r = $urandom_range(0, 99);
			e = ev(REQ_ACK, m_last_ack[SEQ_WIDTH-1:0], 1'b1, 16'($urandom),
				1'($urandom), 1'($urandom));
			if (r >= 97) begin
				e.ack_flag = 1'b0;
				e.ack_number = 16'($urandom);
			end else if (r >= 95) begin
				e.req_type = REQ_UNKNOWN;
			end else if (r >= 90) begin
				e.req_type = REQ_SEND;
			end
			send_evt(e);
			if (e.req_type == REQ_ACK && e.ack_flag && m_cwnd == WIN_MAX)
				pinned++;
			count++;
		end
	endtask

	// end the source, retransmit the final packet, acknowledge it, keep going
	task automatic test_end_of_transfer();
		int unsigned count;
		prepare_phase(11'd16, 1'b0);
		fin_allowed = 1'b1;
		count = 0;
		while (!m_ended && count < 400) begin
			send_evt(traffic_item());
			count++;
		end
		send_evt(ev(REQ_ACK, 16'(m_taken - 17'd2), 1'b1, 16'($urandom), 1'b1, 1'b1));
		send_evt(ev(REQ_TIMEOUT, 16'($urandom), 1'b1, 16'($urandom), 1'b1, 1'b1));
		send_evt(ev(REQ_SEND, 16'($urandom), 1'b1, 16'($urandom), 1'b1, 1'b1));
		send_evt(ev(REQ_ACK, 16'(m_taken - 17'd1), 1'b1, 16'($urandom), 1'b1, 1'b1));
		send_evt(ev(REQ_SEND, 16'($urandom), 1'b1, 16'($urandom), 1'b1, 1'b1));
		repeat (40)
			send_evt(traffic_item());
	endtask

	// result ready: random stalls
	initial begin : result_stalls
		int unsigned hold;
		forever begin
			@(negedge clk);
			hold = pick_gap();
			if (hold != 0) begin
				res_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			res_ready <= 1'b1;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (window_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with nothing expected", $time);
				mismatches++;
			end else begin
				want = window_results.pop_front();
				if (res_item !== want) begin
					if (mismatches < 10) begin
						$display("%0t: exp sv=%0b sn=%0h new=%0b fin=%0b pig=%0h tmr=%0d",
							$time, want.send_valid, want.send_number, want.send_is_new,
							want.send_fin, want.piggyback_ack, want.timer_cmd,
							" win=%0d thr=%0d ph=%0d done=%0b", want.window_now,
							want.threshold_now, want.phase_now, want.transfer_done);
						$display("%0t: got sv=%0b sn=%0h new=%0b fin=%0b pig=%0h tmr=%0d",
							$time, res_item.send_valid, res_item.send_number,
							res_item.send_is_new, res_item.send_fin, res_item.piggyback_ack,
							res_item.timer_cmd, " win=%0d thr=%0d ph=%0d done=%0b",
							res_item.window_now, res_item.threshold_now, res_item.phase_now,
							res_item.transfer_done);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		m_thresh = THRESH_RESET;
		m_phase = PH_SLOW;
		m_cwnd = WIN_WIDTH'(1);
		m_dups = '0;
		m_avoid = '0;
		m_last_ack = '1;
		m_next = '0;
		m_base = '0;
		m_taken = '0;
		m_ended = 1'b0;
		m_peer = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(11'd1, 1'b0);
		test_random_traffic(11'd1024, 1'b1);
		test_random_traffic(11'($urandom_range(2, 1023)), 1'b0);
		test_window_saturation();
		test_random_traffic(11'd64, 1'b0);
		test_end_of_transfer();

		wait_results_done();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && window_results.size() == 0)
			$display("reno_congestion_window_sender_test: PASS");
		else
			$display("reno_congestion_window_sender_test: FAIL");
		$finish;
	end

endmodule
